@@ rtl/core/mtsd_pkg.sv @@
// ----------------------------------------------------------------------------
// mtsd_pkg
// Shared widths, constants and types of the modulated tape sensor detector.
// ----------------------------------------------------------------------------
package mtsd_pkg;

    localparam int SENSOR_COUNT       = 5;
    localparam int READINGS_PER_PHASE = 5;

    // Fixed by the sample ports: one lane per sensor input
    localparam int LANES    = 5;
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 13;
    localparam int THRESH_W = 11;
    localparam int IDX_W    = $clog2(READINGS_PER_PHASE + 1);

    // Reciprocal divide of a SUM_W-bit sum by READINGS_PER_PHASE, exact over the range
    localparam int DIV_SHIFT = SUM_W + $clog2(READINGS_PER_PHASE);
    localparam int DIV_MULT  = (1 << DIV_SHIFT) / READINGS_PER_PHASE + 1;
    localparam int PROD_W    = SUM_W + DIV_SHIFT + 1;

    localparam logic signed [THRESH_W-1:0] LOW_THRESHOLD_RESET  = 11'sd300;
    localparam logic signed [THRESH_W-1:0] HIGH_THRESHOLD_RESET = 11'sd400;

    // Configuration register indexes
    localparam logic CFG_LOW_THRESHOLD  = 1'b0;
    localparam logic CFG_HIGH_THRESHOLD = 1'b1;

    // Per-step commands from the sequencer to every lane
    typedef struct packed {
        logic clear_lit;
        logic clear_dark;
        logic add_lit;
        logic add_dark;
        logic eval;
    } t_lane_ctrl;

    // What one lane found at this step
    typedef struct packed {
        logic on_tape;
        logic detected;
        logic lost;
    } t_lane_status;

    typedef struct packed {
        logic             emitter_on;
        logic             round_done;
        logic [LANES-1:0] detected_mask;
        logic [LANES-1:0] lost_mask;
        logic [LANES-1:0] on_tape_mask;
    } t_result;

endpackage

@@ rtl/core/mtsd_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtsd_ctrl
// Round sequencer: lit wait, lit reading, dark wait, dark reading.
// ----------------------------------------------------------------------------
module mtsd_ctrl
    import mtsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    output t_lane_ctrl o_ctrl,
    output logic       o_emitter_on
);

    typedef enum logic [1:0] {
        LIT_WAIT  = 2'd0,
        LIT_READ  = 2'd1,
        DARK_WAIT = 2'd2,
        DARK_READ = 2'd3
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        o_ctrl  = '0;
        if (i_step) begin
            case (r_phase)
                LIT_WAIT: begin
                    n_phase          = LIT_READ;
                    n_idx            = '0;
                    o_ctrl.clear_lit = 1'b1;
                end
                DARK_WAIT: begin
                    n_phase           = DARK_READ;
                    n_idx             = '0;
                    o_ctrl.clear_dark = 1'b1;
                end
                LIT_READ: begin
                    if (r_idx < IDX_W'(READINGS_PER_PHASE)) begin
                        o_ctrl.add_lit = 1'b1;
                        n_idx          = r_idx + 1'b1;
                    end else begin
                        n_phase = DARK_WAIT;
                    end
                end
                DARK_READ: begin
                    if (r_idx < IDX_W'(READINGS_PER_PHASE)) begin
                        o_ctrl.add_dark = 1'b1;
                        n_idx           = r_idx + 1'b1;
                    end else begin
                        // closing expiry of the dark half: evaluate, relight
                        o_ctrl.eval = 1'b1;
                        n_phase     = LIT_WAIT;
                    end
                end
                default: begin
                    n_phase = LIT_WAIT;
                end
            endcase
        end
    end

    assign o_emitter_on = (n_phase == LIT_WAIT) || (n_phase == LIT_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= LIT_WAIT;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

endmodule

@@ rtl/core/mtsd_lane.sv @@
// ----------------------------------------------------------------------------
// mtsd_lane
// One sensor: lit and dark sums, averaging, hysteresis and on-tape flag.
// ----------------------------------------------------------------------------
module mtsd_lane
    import mtsd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_lane_ctrl                 i_ctrl,
    input  logic [SAMPLE_W-1:0]        i_sample,
    input  logic signed [THRESH_W-1:0] i_low_threshold,
    input  logic signed [THRESH_W-1:0] i_high_threshold,
    output t_lane_status               o_status
);

    logic [SUM_W-1:0]      r_lit_sum;
    logic [SUM_W-1:0]      r_dark_sum;
    logic                  r_on_tape;
    logic [PROD_W-1:0]     w_lit_prod;
    logic [PROD_W-1:0]     w_dark_prod;
    logic [SUM_W-1:0]      w_lit_avg;
    logic [SUM_W-1:0]      w_dark_avg;
    logic signed [SUM_W:0] w_diff;
    logic                  w_below;
    logic                  w_above;

    assign w_lit_prod  = PROD_W'(r_lit_sum) * PROD_W'(DIV_MULT);
    assign w_dark_prod = PROD_W'(r_dark_sum) * PROD_W'(DIV_MULT);
    assign w_lit_avg   = w_lit_prod[DIV_SHIFT +: SUM_W];
    assign w_dark_avg  = w_dark_prod[DIV_SHIFT +: SUM_W];

    assign w_diff  = $signed({1'b0, w_dark_avg}) - $signed({1'b0, w_lit_avg});
    assign w_below = w_diff < (SUM_W + 1)'(i_low_threshold);
    assign w_above = w_diff > (SUM_W + 1)'(i_high_threshold);

    // on-tape test wins when the thresholds overlap
    always_comb begin
        o_status.on_tape  = r_on_tape;
        o_status.detected = 1'b0;
        o_status.lost     = 1'b0;
        if (i_ctrl.eval) begin
            if (w_below) begin
                o_status.on_tape  = 1'b1;
                o_status.detected = !r_on_tape;
            end else if (w_above) begin
                o_status.on_tape = 1'b0;
                o_status.lost    = r_on_tape;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear_lit) begin
            r_lit_sum <= '0;
        end else if (i_ctrl.add_lit) begin
            r_lit_sum <= r_lit_sum + SUM_W'(i_sample);
        end
        if (i_ctrl.clear_dark) begin
            r_dark_sum <= '0;
        end else if (i_ctrl.add_dark) begin
            r_dark_sum <= r_dark_sum + SUM_W'(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_tape <= 1'b0;
        end else begin
            r_on_tape <= o_status.on_tape;
        end
    end

endmodule

@@ rtl/core/modulated_tape_sensor_detector.sv @@
// ----------------------------------------------------------------------------
// modulated_tape_sensor_detector
// Synchronous IR reflectance tape detection with hysteresis, five sensor lanes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_timer_expired, i_sample_a..e
//  result    out        o_valid / i_stall         o_emitter_on, o_round_done, masks
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One transaction a cycle while o_stall is low; its result is registered.
//  All lanes update and the merge stage builds the masks in the accepting cycle.
//  A skid register holds one extra result while the output is stalled; o_stall
//  rises when that register is full, and while reset is held.
//  Synchronous active-low reset restores phase, flags and default thresholds.
// ----------------------------------------------------------------------------
module modulated_tape_sensor_detector
    import mtsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_timer_expired,
    input  logic [SAMPLE_W-1:0] i_sample_a,
    input  logic [SAMPLE_W-1:0] i_sample_b,
    input  logic [SAMPLE_W-1:0] i_sample_c,
    input  logic [SAMPLE_W-1:0] i_sample_d,
    input  logic [SAMPLE_W-1:0] i_sample_e,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_emitter_on,
    output logic                o_round_done,
    output logic [LANES-1:0]    o_detected_mask,
    output logic [LANES-1:0]    o_lost_mask,
    output logic [LANES-1:0]    o_on_tape_mask,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [THRESH_W-1:0] i_cfg_data
);

    logic signed [THRESH_W-1:0] r_low_threshold;
    logic signed [THRESH_W-1:0] r_high_threshold;
    logic                       w_in_acc;
    logic                       w_out_acc;
    logic                       w_step;
    t_lane_ctrl                 w_ctrl;
    logic                       w_emitter_on;
    logic [SAMPLE_W-1:0]        w_sample [LANES];
    t_lane_status               w_status [LANES];
    t_result                    w_result;
    t_result                    r_out;
    t_result                    r_skid;
    logic                       r_out_valid;
    logic                       r_skid_valid;

    assign o_cfg_ready = i_rst_n;
    assign o_stall     = r_skid_valid || !i_rst_n;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_acc   = r_out_valid && !i_stall;
    assign w_step      = w_in_acc && i_timer_expired;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_threshold  <= LOW_THRESHOLD_RESET;
            r_high_threshold <= HIGH_THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOW_THRESHOLD:  r_low_threshold  <= $signed(i_cfg_data);
                CFG_HIGH_THRESHOLD: r_high_threshold <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    mtsd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .o_ctrl       (w_ctrl),
        .o_emitter_on (w_emitter_on)
    );

    assign w_sample[0] = i_sample_a;
    assign w_sample[1] = i_sample_b;
    assign w_sample[2] = i_sample_c;
    assign w_sample[3] = i_sample_d;
    assign w_sample[4] = i_sample_e;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        t_lane_ctrl w_lane_ctrl;

        // lanes past the sensor count never see a command and stay off tape
        assign w_lane_ctrl = (g < SENSOR_COUNT) ? w_ctrl : '0;

        mtsd_lane u_lane (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_ctrl           (w_lane_ctrl),
            .i_sample         (w_sample[g]),
            .i_low_threshold  (r_low_threshold),
            .i_high_threshold (r_high_threshold),
            .o_status         (w_status[g])
        );

        assign w_result.detected_mask[g] = w_status[g].detected;
        assign w_result.lost_mask[g]     = w_status[g].lost;
        assign w_result.on_tape_mask[g]  = w_status[g].on_tape;
    end

    assign w_result.emitter_on = w_emitter_on;
    assign w_result.round_done = w_ctrl.eval;

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_acc) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_acc) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end else if (w_in_acc) begin
            r_skid <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_emitter_on    = r_out.emitter_on;
    assign o_round_done    = r_out.round_done;
    assign o_detected_mask = r_out.detected_mask;
    assign o_lost_mask     = r_out.lost_mask;
    assign o_on_tape_mask  = r_out.on_tape_mask;

endmodule

@@ rtl/core/mtsd_checker.sv @@
// ----------------------------------------------------------------------------
// mtsd_checker
// Port-level assertions on the tape sensor detector, bound to the top level.
// ----------------------------------------------------------------------------
module mtsd_checker
    import mtsd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic                o_emitter_on,
    input logic                o_round_done,
    input logic [LANES-1:0]    o_detected_mask,
    input logic [LANES-1:0]    o_lost_mask,
    input logic [LANES-1:0]    o_on_tape_mask
);

    // closing a round relights the emitter
    a_done_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_round_done |-> o_emitter_on)
        else $error("round closed with emitter off");

    // detected and lost masks are set only on the closing transaction of a round
    a_masks_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_round_done |-> (o_detected_mask == '0) && (o_lost_mask == '0))
        else $error("detected or lost outside a round close");

    // a detection leaves the sensor on tape, a loss leaves it off
    a_mask_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_detected_mask & ~o_on_tape_mask) == '0)
                 && ((o_lost_mask & o_on_tape_mask) == '0))
        else $error("detected or lost mask disagrees with on-tape mask");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_emitter_on) && $stable(o_round_done)
            && $stable(o_detected_mask) && $stable(o_lost_mask)
            && $stable(o_on_tape_mask))
        else $error("stalled result changed");

endmodule

bind modulated_tape_sensor_detector mtsd_checker u_mtsd_checker (.*);
